### rtl/gda_pkg.sv
// Shared types, constants and calendar helpers for the Gregorian date adder.
`timescale 1ns / 1ps

package gda_pkg;

    localparam logic [2:0] CMD_DAYS    = 3'd0;
    localparam logic [2:0] CMD_WEEKS   = 3'd1;
    localparam logic [2:0] CMD_MONTHS  = 3'd2;
    localparam logic [2:0] CMD_YEARS   = 3'd3;
    localparam logic [2:0] CMD_DECADES = 3'd4;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    localparam logic [4:0] DAYS_FEB_LEAP   = 5'd29;
    localparam logic [4:0] DAYS_DEC        = 5'd31;
    localparam logic [4:0] DAY_FIRST       = 5'd1;
    localparam logic [8:0] CYCLE_YEARS     = 9'd400;
    localparam logic [8:0] CENTURY_YEARS   = 9'd100;
    localparam int         DAYS_PER_WEEK   = 7;
    localparam int         YEARS_PER_DEC   = 10;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic mod_step;
        logic check;
        logic day_step;
        logic month_step;
        logic year_step;
        logic out_load;
    } gda_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic       mod_done;
        logic       bad_now;
        logic       day_fin;
        logic       month_fin;
        logic       out_free;
        logic [2:0] command;
    } gda_stat_t;

    // leap test on the year modulo 400
    function automatic logic is_leap(input logic [8:0] r400);
        return (r400 == 9'd0) ||
               ((r400[1:0] == 2'd0) && (r400 != CENTURY_YEARS) &&
                (r400 != 9'(2 * CENTURY_YEARS)) && (r400 != 9'(3 * CENTURY_YEARS)));
    endfunction

    // length of a month, zero for a month code that is not valid
    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [3:0] idx;
        idx = m - 4'd1;
        if (m < MONTH_JAN || m > MONTH_DEC) begin
            return 5'd0;
        end else if (m == MONTH_FEB) begin
            return leap ? DAYS_FEB_LEAP : MONTH_LEN[1];
        end else begin
            return MONTH_LEN[idx];
        end
    endfunction

endpackage

### rtl/gda_ctrl.sv
// Sequencer for the date adder: request intake, phase stepping, result hand-off.
`timescale 1ns / 1ps

module gda_ctrl
    import gda_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  gda_stat_t stat,
    output gda_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MOD    = 3'd1;
    localparam logic [2:0] ST_CHECK  = 3'd2;
    localparam logic [2:0] ST_DAYS   = 3'd3;
    localparam logic [2:0] ST_MONTHS = 3'd4;
    localparam logic [2:0] ST_YEARS  = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MOD;
                end
            end
            ST_MOD: begin
                cmd.mod_step = 1'b1;
                if (stat.mod_done) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.check = 1'b1;
                if (stat.bad_now) begin
                    state_next = ST_FINISH;
                end else if (stat.command == CMD_DAYS || stat.command == CMD_WEEKS) begin
                    state_next = ST_DAYS;
                end else if (stat.command == CMD_MONTHS) begin
                    state_next = ST_MONTHS;
                end else if (stat.command == CMD_YEARS || stat.command == CMD_DECADES) begin
                    state_next = ST_YEARS;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_DAYS: begin
                cmd.day_step = 1'b1;
                if (stat.day_fin) begin
                    state_next = ST_FINISH;
                end
            end
            ST_MONTHS: begin
                if (stat.month_fin) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.month_step = 1'b1;
                end
            end
            ST_YEARS: begin
                cmd.year_step = 1'b1;
                state_next    = ST_FINISH;
            end
            ST_FINISH: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/gda_datapath.sv
// Date registers, year-mod-400 tracking, day/month/year stepping and result register.
`timescale 1ns / 1ps

module gda_datapath
    import gda_pkg::*;
#(
    parameter int YEAR_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  gda_cmd_t    cmd,
    output gda_stat_t   stat,
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata
);

    localparam logic [YEAR_BITS-1:0] YEAR_MAX   = '1;
    localparam logic [32:0]          YEAR_LIMIT = (33'd1 << YEAR_BITS) - 33'd1;

    // byte weights of the year modulo 400, and ceil(2^26 / 400)
    localparam logic [8:0]  R400_B1    = 9'd256;
    localparam logic [8:0]  R400_B2    = 9'd336;
    localparam logic [8:0]  R400_B3    = 9'd16;
    localparam logic [17:0] R400_RECIP = 18'd167773;

    localparam logic [1:0] MOD_FOLD = 2'd0;
    localparam logic [1:0] MOD_QUO  = 2'd1;
    localparam logic [1:0] MOD_REM  = 2'd2;

    logic [2:0]           command_reg;
    logic [17:0]          rem_reg;
    logic [4:0]           day_reg;
    logic [3:0]           month_reg;
    logic [YEAR_BITS-1:0] year_reg;
    logic [15:0]          year_raw_reg;
    logic                 year_hi_reg;
    logic [8:0]           r400_reg;
    logic [1:0]           mod_phase_reg;
    logic [17:0]          mod_sum_reg;
    logic [8:0]           mod_quo_reg;
    logic                 bad_reg;
    logic                 ovf_reg;
    logic                 m_tvalid_reg;
    logic [31:0]          m_tdata_reg;

    // request fields
    logic [2:0]  in_command;
    logic [14:0] in_amount;
    logic [4:0]  in_day;
    logic [3:0]  in_month;
    logic [15:0] in_year;
    logic [31:0] in_year_ext;

    assign in_command  = s_tdata[2:0];
    assign in_amount   = s_tdata[17:3];
    assign in_day      = s_tdata[22:18];
    assign in_month    = s_tdata[26:23];
    assign in_year     = s_tdata[42:27];
    assign in_year_ext = 32'(in_year);

    logic                 leap_cur;
    logic [4:0]           dim_cur;
    logic [4:0]           left;
    logic                 at_dec;
    logic                 at_top;
    logic [3:0]           month_nx;
    logic [8:0]           r400_inc;
    logic [8:0]           r400_nx;
    logic [YEAR_BITS-1:0] year_nx;
    logic [4:0]           dim_nx;
    logic [17:0]          mod_fold;
    logic [8:0]           mod_quo;
    logic [17:0]          mod_rem;
    logic [21:0]          year_add;
    logic [32:0]          year_sum;
    logic [31:0]          year_ext;

    always_comb begin
        leap_cur  = is_leap(r400_reg);
        dim_cur   = month_days(month_reg, leap_cur);
        left      = dim_cur - day_reg;
        at_dec    = (month_reg == MONTH_DEC);
        at_top    = at_dec && (year_reg == YEAR_MAX);
        r400_inc  = (r400_reg == CYCLE_YEARS - 9'd1) ? 9'd0 : r400_reg + 9'd1;
        month_nx  = at_dec ? MONTH_JAN : month_reg + 4'd1;
        r400_nx   = at_dec ? r400_inc : r400_reg;
        year_nx   = at_dec ? year_reg + 1'b1 : year_reg;
        dim_nx    = month_days(month_nx, is_leap(r400_nx));
        year_ext  = 32'(year_reg);
        // congruent to the year mod 400, below 2^18
        mod_fold  = 18'(year_ext[7:0]) +
                    18'(year_ext[15:8]) * 18'(R400_B1) +
                    18'(year_ext[23:16]) * 18'(R400_B2) +
                    18'(year_ext[31:24]) * 18'(R400_B3);
        mod_quo   = 9'((36'(mod_sum_reg) * 36'(R400_RECIP)) >> 26);
        mod_rem   = mod_sum_reg - 18'(mod_quo_reg) * 18'(CYCLE_YEARS);
        year_add  = (command_reg == CMD_DECADES) ?
                    22'(rem_reg) * 22'(YEARS_PER_DEC) : 22'(rem_reg);
        year_sum  = 33'(year_reg) + 33'(year_add);
    end

    assign stat.mod_done  = (mod_phase_reg == MOD_REM);
    assign stat.bad_now   = (day_reg == 5'd0) || (dim_cur == 5'd0) || year_hi_reg ||
                            (day_reg > dim_cur);
    assign stat.day_fin   = (rem_reg <= 18'(left)) || at_top;
    assign stat.month_fin = (rem_reg == 18'd0) || at_top;
    assign stat.out_free  = !m_tvalid_reg || m_tready;
    assign stat.command   = command_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            command_reg   <= in_command;
            rem_reg       <= (in_command == CMD_WEEKS) ?
                             18'(in_amount) * 18'(DAYS_PER_WEEK) : 18'(in_amount);
            day_reg       <= in_day;
            month_reg     <= in_month;
            year_reg      <= in_year_ext[YEAR_BITS-1:0];
            year_raw_reg  <= in_year;
            year_hi_reg   <= (in_year_ext >> YEAR_BITS) != 32'd0;
            r400_reg      <= 9'd0;
            mod_phase_reg <= MOD_FOLD;
            bad_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
        end else if (cmd.mod_step) begin
            // year mod 400: byte fold, reciprocal quotient, remainder
            if (mod_phase_reg == MOD_FOLD) begin
                mod_sum_reg <= mod_fold;
            end else if (mod_phase_reg == MOD_QUO) begin
                mod_quo_reg <= mod_quo;
            end else begin
                r400_reg <= mod_rem[8:0];
            end
            mod_phase_reg <= mod_phase_reg + 2'd1;
        end else if (cmd.check) begin
            bad_reg <= stat.bad_now;
        end else if (cmd.day_step) begin
            if (rem_reg <= 18'(left)) begin
                day_reg <= day_reg + rem_reg[4:0];
            end else if (at_top) begin
                day_reg <= DAYS_DEC;
                ovf_reg <= 1'b1;
            end else begin
                rem_reg   <= rem_reg - (18'(left) + 18'd1);
                month_reg <= month_nx;
                year_reg  <= year_nx;
                r400_reg  <= r400_nx;
                day_reg   <= DAY_FIRST;
            end
        end else if (cmd.month_step) begin
            // cascaded clamp: each step limits the day to the new month
            month_reg <= month_nx;
            year_reg  <= year_nx;
            r400_reg  <= r400_nx;
            rem_reg   <= rem_reg - 18'd1;
            if (day_reg > dim_nx) begin
                day_reg <= dim_nx;
            end
        end else if (cmd.year_step) begin
            if (year_sum > YEAR_LIMIT) begin
                year_reg <= YEAR_MAX;
                ovf_reg  <= 1'b1;
            end else begin
                year_reg <= year_sum[YEAR_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // month overflow: stepping stops at December of the top year
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= {5'd0,
                            ovf_reg | (command_reg == CMD_MONTHS && at_top &&
                                       rem_reg != 18'd0 && !bad_reg),
                            bad_reg,
                            bad_reg ? year_raw_reg : year_ext[15:0],
                            month_reg,
                            day_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### rtl/gregorian_date_adder.sv
// Top level of the Gregorian date adder: controller and datapath.
//
//  channel | direction | tdata fields, lowest bit up
//  s_      | in        | command[2:0] amount[17:3] day_in[22:18] month_in[26:23] year_in[42:27]
//  m_      | out       | day_out[4:0] month_out[8:5] year_out[24:9] bad_date[25]
//          |           | year_overflow[26]
//
// One request at a time. A request passes through intake, the year mod 400 (byte fold,
// reciprocal quotient, remainder), the date check and the phase: days/weeks step one
// month boundary at a time, months step one month at a time, years/decades add the whole
// amount; then the result register is loaded once the output is free. Reset is
// synchronous, active low, and clears the controller and m_tvalid.
// A held result does not block intake of the next request.
`timescale 1ns / 1ps

module gregorian_date_adder
    import gda_pkg::*;
#(
    parameter int YEAR_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // command, amount, day_in, month_in, year_in, zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // day_out, month_out, year_out, bad_date,
                                   // year_overflow, zero fill
);

    gda_cmd_t  cmd;
    gda_stat_t stat;

    gda_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gda_datapath #(
        .YEAR_BITS (YEAR_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

### bench/gregorian_date_adder_tb.sv
// Self-checking bench for the Gregorian date adder: driver, monitor and date predictor.
`timescale 1ns / 1ps

module gregorian_date_adder_tb;
    import gda_pkg::*;

    localparam int YEAR_W = 16;
    localparam int unsigned YEAR_TOP = (1 << YEAR_W) - 1;
    localparam int IDLE_LIMIT = 100000;
    localparam int RANDOM_REQS = 580;

    // command codes the block does not know; it passes the date through
    localparam logic [2:0] CMD_RSV5 = 3'd5;
    localparam logic [2:0] CMD_RSV6 = 3'd6;
    localparam logic [2:0] CMD_RSV7 = 3'd7;

    typedef struct packed {
        logic        drain;   // hold this request until every result is back
        logic [2:0]  cmd;
        logic [14:0] amount;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [15:0] year;
    } date_req_t;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [15:0] year;
        logic        bad;
        logic        ovf;
    } date_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // command, amount, day_in, month_in, year_in, zero fill
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // day_out, month_out, year_out, bad_date, year_overflow

    date_req_t req_backlog[$];
    date_res_t due_dates[$];
    date_req_t req_on_bus;
    bit        req_taken = 1'b0;
    int        results_seen = 0;
    int        fails = 0;
    int        quiet_cycles = 0;
    int        hold_left = 0;
    bit        hold_used = 1'b0;
    bit        quiet;

    gregorian_date_adder #(.YEAR_BITS(YEAR_W)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
        if (m < MONTH_JAN || m > MONTH_DEC) return 0;
        if (m == MONTH_FEB) begin
            return ((y % 400 == 0) || (y % 4 == 0 && y % 100 != 0)) ? 29 : 28;
        end
        return (m == 4 || m == 6 || m == 9 || m == 11) ? 30 : 31;
    endfunction

    function automatic date_res_t advance_date(date_req_t rq);
        date_res_t   res;
        int unsigned d, m, y, rem, room, add, i;
        bit          bad, ovf;
        d = rq.day;
        m = rq.month;
        y = rq.year;
        bad = 1'b0;
        ovf = 1'b0;
        if (d == 0 || m < MONTH_JAN || m > MONTH_DEC || y > YEAR_TOP ||
            d > days_in_month(m, y)) begin
            bad = 1'b1;
        end else begin
            case (rq.cmd)
                CMD_DAYS, CMD_WEEKS: begin
                    rem = (rq.cmd == CMD_WEEKS) ? rq.amount * DAYS_PER_WEEK : rq.amount;
                    while (1) begin
                        room = days_in_month(m, y) - d;
                        if (rem <= room) begin
                            d += rem;
                            break;
                        end
                        rem -= room + 1;
                        if (m == MONTH_DEC) begin
                            if (y >= YEAR_TOP) begin
                                d = DAYS_DEC;
                                ovf = 1'b1;
                                break;
                            end
                            y++;
                            m = MONTH_JAN;
                        end else begin
                            m++;
                        end
                        d = 1;
                    end
                end
                CMD_MONTHS: begin
                    // day is clamped at every step, so short months cascade
                    for (i = 0; i < rq.amount; i++) begin
                        if (m == MONTH_DEC) begin
                            if (y >= YEAR_TOP) begin
                                ovf = 1'b1;
                                break;
                            end
                            y++;
                            m = MONTH_JAN;
                        end else begin
                            m++;
                        end
                        if (d > days_in_month(m, y)) d = days_in_month(m, y);
                    end
                end
                CMD_YEARS, CMD_DECADES: begin
                    add = (rq.cmd == CMD_DECADES) ? rq.amount * YEARS_PER_DEC : rq.amount;
                    if (add > YEAR_TOP - y) begin
                        y = YEAR_TOP;
                        ovf = 1'b1;
                    end else begin
                        y += add;
                    end
                end
                default: ;
            endcase
        end
        res.day = 5'(d);
        res.month = 4'(m);
        res.year = 16'(y);
        res.bad = bad;
        res.ovf = ovf;
        return res;
    endfunction

    function automatic date_req_t random_date_req();
        date_req_t   rq;
        int unsigned pick, lim;
        rq.drain = 1'b0;
        if ($urandom_range(99) < 8) rq.cmd = 3'($urandom_range(CMD_RSV7, CMD_RSV5));
        else rq.cmd = 3'($urandom_range(CMD_DECADES, CMD_DAYS));
        pick = $urandom_range(99);
        if (pick < 2) rq.amount = 15'($urandom_range(32767));
        else if (pick < 12) rq.amount = 15'($urandom_range(2047));
        else rq.amount = 15'($urandom_range(60));
        pick = $urandom_range(99);
        if (pick < 8) begin
            // random fields, some broken: zero day, bad month, day past month end
            rq.day = 5'($urandom_range(31));
            rq.month = 4'($urandom_range(15));
            rq.year = 16'($urandom);
        end else begin
            if (pick < 20) rq.year = 16'(YEAR_TOP - $urandom_range(2));
            else if (pick < 40) rq.year = 16'($urandom_range(163) * 400 + $urandom_range(3) * 100);
            else rq.year = 16'($urandom);
            rq.month = 4'($urandom_range(MONTH_DEC, MONTH_JAN));
            lim = days_in_month(rq.month, rq.year);
            rq.day = ($urandom_range(99) < 30) ? 5'(lim) : 5'($urandom_range(lim, 1));
        end
        return rq;
    endfunction

    task automatic push_req(logic [2:0] cmd, int unsigned amt, int unsigned d,
                            int unsigned m, int unsigned y);
        date_req_t rq;
        rq.drain = 1'b0;
        rq.cmd = cmd;
        rq.amount = 15'(amt);
        rq.day = 5'(d);
        rq.month = 4'(m);
        rq.year = 16'(y);
        req_backlog.push_back(rq);
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    // idling is switched off for a stretch of results
    assign quiet = (results_seen >= 350 && results_seen < 470);

    // request driver
    always @(negedge aclk) begin
        logic        nv;
        logic [47:0] nd;
        date_req_t   rq;
        nv = s_tvalid;
        nd = s_tdata;
        if (req_taken) begin
            nv = 1'b0;
            req_taken = 1'b0;
        end
        if (aresetn && !nv && req_backlog.size() != 0) begin
            if (req_backlog[0].drain && due_dates.size() != 0) begin
                nv = 1'b0;
            end else if (!quiet && $urandom_range(99) < 12) begin
                nv = 1'b0;
            end else begin
                rq = req_backlog.pop_front();
                req_on_bus = rq;
                nd = {5'd0, rq.year, rq.month, rq.day, rq.amount, rq.cmd};
                nv = 1'b1;
            end
        end
        s_tvalid <= nv;
        s_tdata <= nd;
    end

    // result ready, with one long hold-off so the block backs up
    always @(negedge aclk) begin
        logic rdy;
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (!hold_used && results_seen >= 100) begin
            hold_used = 1'b1;
            hold_left = 399;
            rdy = 1'b0;
        end else begin
            rdy = quiet || ($urandom_range(99) >= 12);
        end
        m_tready <= rdy;
    end

    // monitor, scoreboard and watchdog
    always @(posedge aclk) begin
        date_res_t want;
        bit        moved;
        moved = 1'b0;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                due_dates.push_back(advance_date(req_on_bus));
                req_taken = 1'b1;
                moved = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                moved = 1'b1;
                results_seen++;
                if (due_dates.size() == 0) begin
                    $error("result %h with no request outstanding", m_tdata);
                    fails++;
                end else begin
                    want = due_dates.pop_front();
                    check_field("day_out", want.day, m_tdata[4:0]);
                    check_field("month_out", want.month, m_tdata[8:5]);
                    check_field("year_out", want.year, m_tdata[24:9]);
                    check_field("bad_date", want.bad, m_tdata[25]);
                    check_field("year_overflow", want.ovf, m_tdata[26]);
                end
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        date_req_t rq;
        int        k;

        // zero amount and the largest amounts
        push_req(CMD_DAYS, 0, 15, 6, 2024);
        push_req(CMD_DAYS, 32767, 1, 1, 0);
        push_req(CMD_WEEKS, 32767, 31, 12, 65535);
        push_req(CMD_MONTHS, 32767, 31, 12, 0);
        // leap rule: 400, 100 and 4
        push_req(CMD_WEEKS, 1, 28, 2, 2000);
        push_req(CMD_DAYS, 1, 28, 2, 1900);
        push_req(CMD_DAYS, 1, 28, 2, 2024);
        // clamping to short months, cascading
        push_req(CMD_MONTHS, 1, 31, 1, 2023);
        push_req(CMD_MONTHS, 2, 31, 1, 2024);
        push_req(CMD_MONTHS, 5, 15, 11, 65535);
        // year add from Feb 29 keeps the day; year and decade adds, overflow at the top year
        push_req(CMD_YEARS, 1, 29, 2, 2024);
        push_req(CMD_YEARS, 32767, 1, 1, 65535);
        push_req(CMD_YEARS, 0, 31, 12, 65535);
        push_req(CMD_DECADES, 32767, 1, 1, 0);
        push_req(CMD_DECADES, 10, 5, 5, 65435);
        push_req(CMD_DAYS, 1, 31, 12, 65535);
        // invalid dates
        push_req(CMD_DAYS, 5, 0, 3, 100);
        push_req(CMD_MONTHS, 3, 10, 0, 100);
        push_req(CMD_YEARS, 3, 31, 15, 65535);
        push_req(CMD_DAYS, 1, 31, 4, 2001);
        push_req(CMD_DAYS, 1, 29, 2, 1900);
        // unknown commands
        push_req(CMD_RSV5, 32767, 31, 12, 65535);
        push_req(CMD_RSV6, 100, 1, 1, 1);
        push_req(CMD_RSV7, 32767, 31, 13, 7);

        for (k = 0; k < RANDOM_REQS; k++) begin
            rq = random_date_req();
            if (k == 0 || k == 300) rq.drain = 1'b1;
            req_backlog.push_back(rq);
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (req_backlog.size() != 0 || s_tvalid) @(posedge aclk);
        while (due_dates.size() != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);

        if (fails == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
